// ===== hw/rtl/bftm_pkg.sv =====
// types and constants shared by the tape machine and its testbench
package bftm_pkg;

    localparam int POS_W = 12;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] program_char;
        logic [7:0] input_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]       kind;
        logic [7:0]       out_byte;
        logic             input_taken;
        logic [POS_W-1:0] position;
    } t_out_item;

    // item actions
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_EOL  = 2'd1;
    localparam logic [1:0] ACT_STEP = 2'd2;

    // result kinds
    localparam logic [2:0] K_ACK    = 3'd0;
    localparam logic [2:0] K_OUT    = 3'd1;
    localparam logic [2:0] K_FIN    = 3'd2;
    localparam logic [2:0] K_UCLOSE = 3'd3;
    localparam logic [2:0] K_UOPEN  = 3'd4;
    localparam logic [2:0] K_LOADED = 3'd5;
    localparam logic [2:0] K_NREADY = 3'd6;
    localparam logic [2:0] K_CAP    = 3'd7;

    // program characters
    localparam logic [7:0] CH_OPEN  = 8'h5B; // [
    localparam logic [7:0] CH_CLOSE = 8'h5D; // ]
    localparam logic [7:0] CH_INC   = 8'h2B; // +
    localparam logic [7:0] CH_DEC   = 8'h2D; // -
    localparam logic [7:0] CH_RIGHT = 8'h3E; // >
    localparam logic [7:0] CH_LEFT  = 8'h3C; // <
    localparam logic [7:0] CH_PUT   = 8'h2E; // .
    localparam logic [7:0] CH_GET   = 8'h2C; // ,
    localparam logic [7:0] CH_CPYR  = 8'h3A; // :
    localparam logic [7:0] CH_CPYL  = 8'h3B; // ;
    localparam logic [7:0] CH_DBL   = 8'h2A; // *
    localparam logic [7:0] CH_HALF  = 8'h2F; // /

endpackage

// ===== hw/rtl/bf_tape_machine_step.sv =====
// tape machine top level: program load with bracket matching, one instruction per step
//
//  channel  | signals                               | direction
//  ---------+---------------------------------------+----------
//  in       | i_in_valid, o_in_stall, i_in_item     | into block
//  out      | o_out_valid, i_out_stall, o_out_item  | out of block
//  cfg      | i_cfg_valid, o_cfg_ready, i_cfg_data  | into block
//
//  step: ram read of program, match table and tape, then execute and write back
//  load of ']': bracket stack read, then two match table writes
//  end of load with pending openers: stack read of the top opener; every other item ends in S_IDLE
//  after reset every tape cell is cleared to zero before the first item is taken
//  a result waiting on a stalled output holds off the next item only once it is done
module bf_tape_machine_step #(
    parameter int PROGRAM_DEPTH = 4096,
    parameter int NEST_DEPTH    = 256,
    parameter int TAPE_DEPTH    = 65536
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bftm_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bftm_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);

    localparam int PW  = $clog2(PROGRAM_DEPTH);
    localparam int LW  = PW + 1;
    localparam int SW  = $clog2(NEST_DEPTH);
    localparam int SLW = SW + 1;
    localparam int TW  = $clog2(TAPE_DEPTH);

    localparam logic [LW-1:0]  PROG_MAX  = LW'(PROGRAM_DEPTH);
    localparam logic [SLW-1:0] NEST_MAX  = SLW'(NEST_DEPTH);
    localparam logic [TW-1:0]  TAPE_LAST = TW'(TAPE_DEPTH - 1);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_LD_RD, S_LD_WR, S_EOL_RD, S_EX, S_PUT
    } t_state;

    typedef enum logic [1:0] {
        PH_LOAD, PH_RUN, PH_DONE, PH_ERR
    } t_phase;

    t_state              r_state, n_state;
    t_phase              r_phase, n_phase;
    logic                r_extras;
    logic [SLW-1:0]      r_stack_lvl, n_stack_lvl;
    logic [LW-1:0]       r_len, n_len;
    logic [LW-1:0]       r_pc, n_pc;
    logic [TW-1:0]       r_head, n_head;
    logic [TW-1:0]       r_clr;
    logic [PW-1:0]       r_pos, n_pos;
    logic [PW-1:0]       r_open, n_open;
    logic [7:0]          r_inb, n_inb;
    bftm_pkg::t_out_item r_pend, n_pend;
    bftm_pkg::t_out_item r_out, n_out;
    logic                r_out_valid, n_out_valid;

    // memory ports
    logic            prog_we;
    logic [PW-1:0]   prog_waddr;
    logic [7:0]      prog_wdata;
    logic [PW-1:0]   prog_raddr;
    logic [7:0]      prog_rdata;
    logic            match_we;
    logic [PW-1:0]   match_waddr;
    logic [PW-1:0]   match_wdata;
    logic [PW-1:0]   match_raddr;
    logic [PW-1:0]   match_rdata;
    logic            stack_we;
    logic [SW-1:0]   stack_waddr;
    logic [PW-1:0]   stack_wdata;
    logic [SW-1:0]   stack_raddr;
    logic [PW-1:0]   stack_rdata;
    logic            tape_we;
    logic [TW-1:0]   tape_waddr;
    logic [7:0]      tape_wdata;
    logic [7:0]      tape_rdata;

    logic                in_fire;
    logic                out_fire;
    logic                out_free;
    logic                fin;
    bftm_pkg::t_out_item res;
    logic [TW-1:0]       head_nx;
    logic [TW-1:0]       head_pv;
    logic [SLW-1:0]      lvl_dec;

    bftm_ram #(.DEPTH(PROGRAM_DEPTH), .WIDTH(8)) u_prog (
        .i_clk   (i_clk),
        .i_we    (prog_we),
        .i_waddr (prog_waddr),
        .i_wdata (prog_wdata),
        .i_raddr (prog_raddr),
        .o_rdata (prog_rdata)
    );

    bftm_ram #(.DEPTH(PROGRAM_DEPTH), .WIDTH(PW)) u_match (
        .i_clk   (i_clk),
        .i_we    (match_we),
        .i_waddr (match_waddr),
        .i_wdata (match_wdata),
        .i_raddr (match_raddr),
        .o_rdata (match_rdata)
    );

    bftm_ram #(.DEPTH(NEST_DEPTH), .WIDTH(PW)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stack_we),
        .i_waddr (stack_waddr),
        .i_wdata (stack_wdata),
        .i_raddr (stack_raddr),
        .o_rdata (stack_rdata)
    );

    bftm_ram #(.DEPTH(TAPE_DEPTH), .WIDTH(8)) u_tape (
        .i_clk   (i_clk),
        .i_we    (tape_we),
        .i_waddr (tape_waddr),
        .i_wdata (tape_wdata),
        .i_raddr (r_head),
        .o_rdata (tape_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign in_fire  = i_in_valid && !o_in_stall;
    assign out_fire = r_out_valid && !i_out_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    assign head_nx = (r_head == TAPE_LAST) ? '0 : r_head + TW'(1);
    assign head_pv = (r_head == '0) ? TAPE_LAST : r_head - TW'(1);
    assign lvl_dec = r_stack_lvl - SLW'(1);

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_stack_lvl = r_stack_lvl;
        n_len       = r_len;
        n_pc        = r_pc;
        n_head      = r_head;
        n_pos       = r_pos;
        n_open      = r_open;
        n_inb       = r_inb;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid && !out_fire;
        fin         = 1'b0;
        res         = '{kind: bftm_pkg::K_NREADY, out_byte: 8'd0, input_taken: 1'b0,
                        position: '0};

        prog_we     = 1'b0;
        prog_waddr  = r_len[PW-1:0];
        prog_wdata  = i_in_item.program_char;
        prog_raddr  = r_pc[PW-1:0];
        match_we    = 1'b0;
        match_waddr = r_pos;
        match_wdata = r_open;
        match_raddr = r_pc[PW-1:0];
        stack_we    = 1'b0;
        stack_waddr = r_stack_lvl[SW-1:0];
        stack_wdata = r_len[PW-1:0];
        stack_raddr = lvl_dec[SW-1:0];
        tape_we     = 1'b0;
        tape_waddr  = r_head;
        tape_wdata  = 8'd0;

        unique case (r_state)
            S_CLEAR: begin
                tape_we    = 1'b1;
                tape_waddr = r_clr;
                if (r_clr == TAPE_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    fin = 1'b1;
                    unique case (i_in_item.action)
                        bftm_pkg::ACT_LOAD: begin
                            if (r_phase == PH_LOAD) begin
                                res.position = bftm_pkg::POS_W'(r_len);
                                if (r_len >= PROG_MAX) begin
                                    n_phase  = PH_ERR;
                                    res.kind = bftm_pkg::K_CAP;
                                end else if (i_in_item.program_char == bftm_pkg::CH_OPEN &&
                                             r_stack_lvl >= NEST_MAX) begin
                                    n_phase  = PH_ERR;
                                    res.kind = bftm_pkg::K_CAP;
                                end else if (i_in_item.program_char == bftm_pkg::CH_CLOSE &&
                                             r_stack_lvl == '0) begin
                                    n_phase  = PH_ERR;
                                    res.kind = bftm_pkg::K_UCLOSE;
                                end else begin
                                    prog_we  = 1'b1;
                                    n_len    = r_len + LW'(1);
                                    res.kind = bftm_pkg::K_ACK;
                                    if (i_in_item.program_char == bftm_pkg::CH_OPEN) begin
                                        stack_we    = 1'b1;
                                        n_stack_lvl = r_stack_lvl + SLW'(1);
                                    end else if (i_in_item.program_char ==
                                                 bftm_pkg::CH_CLOSE) begin
                                        // opener position comes back from the stack next cycle
                                        n_stack_lvl = lvl_dec;
                                        n_pos       = r_len[PW-1:0];
                                        fin         = 1'b0;
                                        n_state     = S_LD_RD;
                                    end
                                end
                            end
                        end
                        bftm_pkg::ACT_EOL: begin
                            if (r_phase == PH_LOAD) begin
                                if (r_stack_lvl != '0) begin
                                    fin     = 1'b0;
                                    n_state = S_EOL_RD;
                                end else begin
                                    n_phase  = PH_RUN;
                                    n_pc     = '0;
                                    res.kind = bftm_pkg::K_LOADED;
                                end
                            end
                        end
                        bftm_pkg::ACT_STEP: begin
                            if (r_phase == PH_RUN || r_phase == PH_DONE) begin
                                if (r_pc >= r_len) begin
                                    n_phase  = PH_DONE;
                                    res.kind = bftm_pkg::K_FIN;
                                end else begin
                                    n_inb   = i_in_item.input_byte;
                                    fin     = 1'b0;
                                    n_state = S_EX;
                                end
                            end
                        end
                        default: begin
                            res.kind = bftm_pkg::K_NREADY;
                        end
                    endcase
                end
            end
            S_LD_RD: begin
                match_we    = 1'b1;
                match_waddr = stack_rdata;
                match_wdata = r_pos;
                n_open      = stack_rdata;
                n_state     = S_LD_WR;
            end
            S_LD_WR: begin
                match_we     = 1'b1;
                fin          = 1'b1;
                res.kind     = bftm_pkg::K_ACK;
                res.position = bftm_pkg::POS_W'(r_pos);
            end
            S_EOL_RD: begin
                n_phase      = PH_ERR;
                fin          = 1'b1;
                res.kind     = bftm_pkg::K_UOPEN;
                res.position = bftm_pkg::POS_W'(stack_rdata);
            end
            S_EX: begin
                fin          = 1'b1;
                res.kind     = bftm_pkg::K_ACK;
                res.position = bftm_pkg::POS_W'(r_pc);
                n_pc         = r_pc + LW'(1);
                case (prog_rdata)
                    bftm_pkg::CH_INC: begin
                        tape_we    = 1'b1;
                        tape_wdata = tape_rdata + 8'd1;
                    end
                    bftm_pkg::CH_DEC: begin
                        tape_we    = 1'b1;
                        tape_wdata = tape_rdata - 8'd1;
                    end
                    bftm_pkg::CH_RIGHT: n_head = head_nx;
                    bftm_pkg::CH_LEFT:  n_head = head_pv;
                    bftm_pkg::CH_PUT: begin
                        res.kind     = bftm_pkg::K_OUT;
                        res.out_byte = tape_rdata;
                    end
                    bftm_pkg::CH_GET: begin
                        tape_we         = 1'b1;
                        tape_wdata      = r_inb;
                        res.input_taken = 1'b1;
                    end
                    bftm_pkg::CH_CPYR: begin
                        if (r_extras) begin
                            n_head     = head_nx;
                            tape_we    = 1'b1;
                            tape_waddr = head_nx;
                            tape_wdata = tape_rdata;
                        end
                    end
                    bftm_pkg::CH_CPYL: begin
                        if (r_extras) begin
                            n_head     = head_pv;
                            tape_we    = 1'b1;
                            tape_waddr = head_pv;
                            tape_wdata = tape_rdata;
                        end
                    end
                    bftm_pkg::CH_DBL: begin
                        tape_we    = r_extras;
                        tape_wdata = {tape_rdata[6:0], 1'b0};
                    end
                    bftm_pkg::CH_HALF: begin
                        tape_we    = r_extras;
                        tape_wdata = {1'b0, tape_rdata[7:1]};
                    end
                    bftm_pkg::CH_OPEN: begin
                        if (tape_rdata == 8'd0) begin
                            n_pc = LW'(match_rdata) + LW'(1);
                        end
                    end
                    bftm_pkg::CH_CLOSE: n_pc = LW'(match_rdata);
                    default: ;
                endcase
            end
            S_PUT: begin
                if (out_free) begin
                    n_out       = r_pend;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // a finished result goes straight into the output register if it is free, else it waits in r_pend
        if (fin) begin
            if (out_free) begin
                n_out       = res;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end else begin
                n_pend  = res;
                n_state = S_PUT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_phase     <= PH_LOAD;
            r_extras    <= 1'b0;
            r_stack_lvl <= '0;
            r_len       <= '0;
            r_pc        <= '0;
            r_head      <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_stack_lvl <= n_stack_lvl;
            r_len       <= n_len;
            r_pc        <= n_pc;
            r_head      <= n_head;
            r_out_valid <= n_out_valid;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + TW'(1);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_extras <= i_cfg_data;
            end
        end
        r_pos  <= n_pos;
        r_open <= n_open;
        r_inb  <= n_inb;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    // nesting and program counts never pass their capacity
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stack_lvl <= NEST_MAX)
        else $error("bracket stack level beyond capacity");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= PROG_MAX)
        else $error("program length beyond capacity");

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_ERR |=> r_phase == PH_ERR)
        else $error("left error phase without reset");

    a_step_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_item.action == bftm_pkg::ACT_STEP && r_pc < r_len &&
         (r_phase == PH_RUN || r_phase == PH_DONE)) |=> r_state == S_EX)
        else $error("step did not go to execute");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_head} <= {1'b0, TAPE_LAST})
        else $error("tape head beyond tape");

endmodule

// ===== hw/rtl/bftm_ram.sv =====
// simple dual-port synchronous ram, one write port, one registered read port
module bftm_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== verif/tb.sv =====
// testbench for the tape machine: program load, single-step execution and result checking
`timescale 1ns / 1ps

module tb;

    localparam int PROG_DEPTH    = 4096;
    localparam int NEST_LIMIT    = 256;
    localparam int TAPE_CELLS    = 65536;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int BODY_LEN      = 40;
    localparam int RUN_PHASES    = 6;
    localparam int PHASE_ITEMS   = 70;
    localparam int END_STEP_MAX  = 2000;

    localparam logic [1:0] ACT_UNDEF = 2'd3;

    typedef enum logic [1:0] {
        PH_LOADING,
        PH_RUNNING,
        PH_FINISHED,
        PH_ERROR
    } t_phase;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    bftm_pkg::t_in_item  in_item   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    bftm_pkg::t_out_item out_item;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_data  = 1'b0;

    logic                quiet       = 1'b0;
    int                  error_count = 0;
    int                  cycle_count = 0;
    int                  stall_left  = 0;
    bftm_pkg::t_out_item want_item;
    bftm_pkg::t_out_item expected_results [$];

    // machine state as the predictor sees it
    logic [7:0]  prog_mem   [PROG_DEPTH];
    logic [11:0] jump_mem   [PROG_DEPTH];
    logic [11:0] open_stack [NEST_LIMIT];
    logic [7:0]  tape_model [TAPE_CELLS];
    logic [8:0]  nest_level = '0;
    logic [12:0] prog_len   = '0;
    logic [12:0] pc_model   = '0;
    logic [15:0] head_model = '0;
    t_phase      mach_phase = PH_LOADING;
    logic        extras_on  = 1'b0;

    bf_tape_machine_step #(
        .PROGRAM_DEPTH(PROG_DEPTH),
        .NEST_DEPTH   (NEST_LIMIT),
        .TAPE_DEPTH   (TAPE_CELLS)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [7:0] rand_byte();
        logic [31:0] rnd;
        rnd = $urandom;
        return rnd[7:0];
    endfunction

    function automatic bftm_pkg::t_in_item make_item(input logic [1:0] act,
                                                     input logic [7:0] ch,
                                                     input logic [7:0] b);
        bftm_pkg::t_in_item it;
        it.action       = act;
        it.program_char = ch;
        it.input_byte   = b;
        return it;
    endfunction

    function automatic logic [7:0] command_char(input int idx);
        case (idx)
            0:       return bftm_pkg::CH_INC;
            1:       return bftm_pkg::CH_DEC;
            2:       return bftm_pkg::CH_RIGHT;
            3:       return bftm_pkg::CH_LEFT;
            4:       return bftm_pkg::CH_PUT;
            5:       return bftm_pkg::CH_GET;
            6:       return bftm_pkg::CH_CPYR;
            7:       return bftm_pkg::CH_CPYL;
            8:       return bftm_pkg::CH_DBL;
            default: return bftm_pkg::CH_HALF;
        endcase
    endfunction

    // advances the machine state by one item and returns the result it should give
    function automatic bftm_pkg::t_out_item predict_result(input bftm_pkg::t_in_item it);
        bftm_pkg::t_out_item r;
        logic [7:0]          cur_cell;
        logic [12:0]         next_pc;
        logic [11:0]         opener;
        logic [8:0]          top_idx;
        r      = '0;
        r.kind = bftm_pkg::K_NREADY;
        case (it.action)
            bftm_pkg::ACT_LOAD: begin
                if (mach_phase == PH_LOADING) begin
                    r.position = prog_len[11:0];
                    if (prog_len >= PROG_DEPTH) begin
                        mach_phase = PH_ERROR;
                        r.kind     = bftm_pkg::K_CAP;
                    end else if (it.program_char == bftm_pkg::CH_OPEN &&
                                 nest_level >= NEST_LIMIT) begin
                        mach_phase = PH_ERROR;
                        r.kind     = bftm_pkg::K_CAP;
                    end else if (it.program_char == bftm_pkg::CH_CLOSE &&
                                 nest_level == 9'd0) begin
                        mach_phase = PH_ERROR;
                        r.kind     = bftm_pkg::K_UCLOSE;
                    end else begin
                        if (it.program_char == bftm_pkg::CH_OPEN) begin
                            open_stack[nest_level[7:0]] = prog_len[11:0];
                            nest_level = nest_level + 9'd1;
                        end else if (it.program_char == bftm_pkg::CH_CLOSE) begin
                            nest_level = nest_level - 9'd1;
                            opener     = open_stack[nest_level[7:0]];
                            jump_mem[opener]         = prog_len[11:0];
                            jump_mem[prog_len[11:0]] = opener;
                        end
                        prog_mem[prog_len[11:0]] = it.program_char;
                        prog_len = prog_len + 13'd1;
                        r.kind   = bftm_pkg::K_ACK;
                    end
                end
            end
            bftm_pkg::ACT_EOL: begin
                if (mach_phase == PH_LOADING) begin
                    if (nest_level != 9'd0) begin
                        top_idx    = nest_level - 9'd1;
                        mach_phase = PH_ERROR;
                        r.kind     = bftm_pkg::K_UOPEN;
                        r.position = open_stack[top_idx[7:0]];
                    end else begin
                        mach_phase = PH_RUNNING;
                        pc_model   = '0;
                        r.kind     = bftm_pkg::K_LOADED;
                    end
                end
            end
            bftm_pkg::ACT_STEP: begin
                if (mach_phase == PH_RUNNING || mach_phase == PH_FINISHED) begin
                    if (pc_model >= prog_len) begin
                        mach_phase = PH_FINISHED;
                        r.kind     = bftm_pkg::K_FIN;
                    end else begin
                        cur_cell   = tape_model[head_model];
                        next_pc    = pc_model + 13'd1;
                        r.kind     = bftm_pkg::K_ACK;
                        r.position = pc_model[11:0];
                        // head is 16 bits wide, so it wraps at the tape size by itself
                        case (prog_mem[pc_model[11:0]])
                            bftm_pkg::CH_INC:   tape_model[head_model] = cur_cell + 8'd1;
                            bftm_pkg::CH_DEC:   tape_model[head_model] = cur_cell - 8'd1;
                            bftm_pkg::CH_RIGHT: head_model = head_model + 16'd1;
                            bftm_pkg::CH_LEFT:  head_model = head_model - 16'd1;
                            bftm_pkg::CH_PUT: begin
                                r.kind     = bftm_pkg::K_OUT;
                                r.out_byte = cur_cell;
                            end
                            bftm_pkg::CH_GET: begin
                                tape_model[head_model] = it.input_byte;
                                r.input_taken          = 1'b1;
                            end
                            bftm_pkg::CH_CPYR: begin
                                if (extras_on) begin
                                    head_model = head_model + 16'd1;
                                    tape_model[head_model] = cur_cell;
                                end
                            end
                            bftm_pkg::CH_CPYL: begin
                                if (extras_on) begin
                                    head_model = head_model - 16'd1;
                                    tape_model[head_model] = cur_cell;
                                end
                            end
                            bftm_pkg::CH_DBL: begin
                                if (extras_on) tape_model[head_model] = {cur_cell[6:0], 1'b0};
                            end
                            bftm_pkg::CH_HALF: begin
                                if (extras_on) tape_model[head_model] = {1'b0, cur_cell[7:1]};
                            end
                            bftm_pkg::CH_OPEN: begin
                                if (cur_cell == 8'd0)
                                    next_pc = {1'b0, jump_mem[pc_model[11:0]]} + 13'd1;
                            end
                            bftm_pkg::CH_CLOSE: next_pc = {1'b0, jump_mem[pc_model[11:0]]};
                            default: ;
                        endcase
                        pc_model = next_pc;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR %0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        error_count = error_count + 1;
    endtask

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_item(input bftm_pkg::t_in_item it);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        expected_results.insert(expected_results.size(), predict_result(it));
        @(negedge clk);
    endtask

    task automatic load_char(input logic [7:0] ch);
        send_item(make_item(bftm_pkg::ACT_LOAD, ch, rand_byte()));
    endtask

    task automatic settle_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_extras(input logic val);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        extras_on = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_wrong_phase_loading();
        send_item(make_item(bftm_pkg::ACT_STEP, 8'h00, 8'hFF));
        send_item(make_item(ACT_UNDEF, 8'hFF, 8'h00));
    endtask

    task automatic test_load_program();
        int         i;
        int         pick;
        logic [7:0] ch;
        // opening that runs every non-bracket command once, plus two plain characters
        load_char(bftm_pkg::CH_GET);
        load_char(bftm_pkg::CH_DBL);
        load_char(bftm_pkg::CH_HALF);
        load_char(bftm_pkg::CH_CPYR);
        load_char(bftm_pkg::CH_CPYL);
        load_char(bftm_pkg::CH_PUT);
        load_char(bftm_pkg::CH_LEFT);
        load_char(bftm_pkg::CH_RIGHT);
        load_char(bftm_pkg::CH_INC);
        load_char(bftm_pkg::CH_DEC);
        load_char(8'h00);
        load_char(8'hFF);
        // main loop keeps going while the byte read just before its test is nonzero
        load_char(bftm_pkg::CH_GET);
        load_char(bftm_pkg::CH_OPEN);
        for (i = 0; i < BODY_LEN; i++) begin
            pick = $urandom_range(0, 13);
            if (pick < 10) begin
                load_char(command_char(pick));
            end else if (pick < 12) begin
                ch = rand_byte();
                if (ch == bftm_pkg::CH_OPEN || ch == bftm_pkg::CH_CLOSE) ch = ch ^ 8'h01;
                load_char(ch);
            end else begin
                // short loops that always end: clear, clear with output, scan for zero
                load_char(bftm_pkg::CH_OPEN);
                case ($urandom_range(0, 3))
                    0: load_char(bftm_pkg::CH_DEC);
                    1: begin
                        load_char(bftm_pkg::CH_DEC);
                        load_char(bftm_pkg::CH_PUT);
                    end
                    2: load_char(bftm_pkg::CH_RIGHT);
                    default: load_char(bftm_pkg::CH_LEFT);
                endcase
                load_char(bftm_pkg::CH_CLOSE);
            end
        end
        load_char(bftm_pkg::CH_GET);
        load_char(bftm_pkg::CH_CLOSE);
        load_char(bftm_pkg::CH_PUT);
        send_item(make_item(bftm_pkg::ACT_EOL, rand_byte(), rand_byte()));
    endtask

    task automatic test_wrong_phase_running();
        send_item(make_item(bftm_pkg::ACT_LOAD, bftm_pkg::CH_INC, rand_byte()));
        send_item(make_item(bftm_pkg::ACT_EOL, rand_byte(), rand_byte()));
        send_item(make_item(ACT_UNDEF, rand_byte(), rand_byte()));
    endtask

    task automatic test_directed_steps();
        settle_idle();
        write_extras(1'b1);
        // first instruction reads the all-ones byte, the rest work on it
        send_item(make_item(bftm_pkg::ACT_STEP, rand_byte(), 8'hFF));
        repeat (11) send_item(make_item(bftm_pkg::ACT_STEP, rand_byte(), rand_byte()));
    endtask

    task automatic test_random_steps();
        int                 ph;
        int                 n;
        bftm_pkg::t_in_item it;
        logic [7:0]         b;
        for (ph = 0; ph < RUN_PHASES; ph++) begin
            settle_idle();
            write_extras(ph[0]);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    case ($urandom_range(0, 2))
                        0:       it = make_item(bftm_pkg::ACT_LOAD, rand_byte(), rand_byte());
                        1:       it = make_item(bftm_pkg::ACT_EOL, rand_byte(), rand_byte());
                        default: it = make_item(ACT_UNDEF, rand_byte(), rand_byte());
                    endcase
                end else begin
                    // small bytes keep the clearing loops short; zero would end the program
                    b = rand_byte();
                    if ($urandom_range(0, 3) != 0) b = {5'd0, b[2:0]};
                    if (b == 8'd0) b = 8'h01;
                    it = make_item(bftm_pkg::ACT_STEP, rand_byte(), b);
                end
                send_item(it);
                if ($urandom_range(0, 63) == 0) settle_idle();
            end
        end
    endtask

    task automatic test_program_end();
        int n;
        settle_idle();
        write_extras(1'b0);
        quiet = 1'b1;
        n = 0;
        while (mach_phase != PH_FINISHED && n < END_STEP_MAX) begin
            send_item(make_item(bftm_pkg::ACT_STEP, rand_byte(), 8'h00));
            n++;
        end
        repeat (3) send_item(make_item(bftm_pkg::ACT_STEP, rand_byte(), rand_byte()));
        send_item(make_item(bftm_pkg::ACT_LOAD, bftm_pkg::CH_INC, rand_byte()));
        send_item(make_item(bftm_pkg::ACT_EOL, rand_byte(), rand_byte()));
    endtask

    always @(negedge clk) begin
        if (quiet) stall_left = 0;
        else if (stall_left > 0) stall_left = stall_left - 1;
        else if ($urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 18);
        out_stall <= (stall_left > 0);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result transaction with nothing expected", 32'(out_item),
                                '0);
            end else begin
                want_item = expected_results.pop_front();
                if (out_item.kind !== want_item.kind)
                    report_mismatch("kind", 32'(out_item.kind), 32'(want_item.kind));
                if (out_item.out_byte !== want_item.out_byte)
                    report_mismatch("out_byte", 32'(out_item.out_byte),
                                    32'(want_item.out_byte));
                if (out_item.input_taken !== want_item.input_taken)
                    report_mismatch("input_taken", 32'(out_item.input_taken),
                                    32'(want_item.input_taken));
                if (out_item.position !== want_item.position)
                    report_mismatch("position", 32'(out_item.position),
                                    32'(want_item.position));
            end
        end
    end

    always @(posedge clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles", CYCLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        for (int c = 0; c < TAPE_CELLS; c++) tape_model[c] = 8'd0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        test_wrong_phase_loading();
        test_load_program();
        test_wrong_phase_running();
        test_directed_steps();
        test_random_steps();
        test_program_end();
        settle_idle();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== bf_tape_machine_step.f =====
hw/rtl/bftm_pkg.sv
hw/rtl/bftm_ram.sv
hw/rtl/bf_tape_machine_step.sv
verif/tb.sv
